[rtl/tmd_pkg.sv]
// shared types and constants of the trapezoidal move duration block
// no dependencies

package tmd_pkg;

    localparam int unsigned DIST_W  = 32;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned DUR_W   = 32;
    localparam int unsigned NUM_W   = 90;
    localparam int unsigned MOD_W   = 52;
    localparam int unsigned ACC_W   = 56;
    localparam int unsigned IDX_W   = 1;

    localparam logic [IDX_W-1:0] REG_TOP_FEED_RATE     = 1'd0;
    localparam logic [IDX_W-1:0] REG_AXIS_ACCELERATION = 1'd1;

    localparam logic [CFG_W-1:0] TOP_FEED_RATE_RESET     = 24'd48000;
    localparam logic [CFG_W-1:0] AXIS_ACCELERATION_RESET = 24'd16000;

    // ramp test 225*a*d > 4*f*f
    localparam logic [63:0] RAMP_K       = 64'd225;
    // cruise numerator (11250*a*d + 200*f*f) * 250
    localparam logic [69:0] CRUISE_AD_K  = 70'd11250;
    localparam logic [55:0] CRUISE_FF_K  = 56'd200;
    localparam logic [NUM_W-1:0] CRUISE_SCALE_K = 90'd250;
    // no-cruise numerator (250000*d) * 250000
    localparam logic [49:0] RAMP_D_K     = 50'd250000;
    localparam logic [NUM_W-1:0] RAMP_SCALE_K = 90'd250000;
    // cruise divisor 3*a*f
    localparam logic [49:0] DIV_K        = 50'd3;

    typedef struct packed {
        logic               sqrt_mode;
        logic               done;
        logic               sat;
        logic [NUM_W-1:0]   n;
        logic [NUM_W-1:0]   s;
        logic [MOD_W-1:0]   m;
        logic [ACC_W-1:0]   r_acc;
        logic [DUR_W-1:0]   q;
    } iter_t;

endpackage

[rtl/tmd_front.sv]
// front stages: products, constant scaling, mode select and range precheck
// depends on tmd_pkg

module tmd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_fire,
    input  logic [tmd_pkg::DIST_W-1:0]    move_distance,
    input  logic [tmd_pkg::CFG_W-1:0]     top_feed_rate,
    input  logic [tmd_pkg::CFG_W-1:0]     axis_acceleration,
    output logic                          iter_valid,
    output tmd_pkg::iter_t                iter_data
);

    logic                        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [tmd_pkg::DIST_W-1:0]  d1_reg, d2_reg;
    logic [tmd_pkg::CFG_W-1:0]   f1_reg, a1_reg, a2_reg, a3_reg;
    logic [55:0]                 ad2_reg;
    logic [47:0]                 ff2_reg, af2_reg;
    logic                        dz2_reg, cz2_reg, dz3_reg, cz3_reg, dz4_reg, cz4_reg;
    logic                        cruise3_reg, cruise4_reg;
    logic [69:0]                 x3_reg;
    logic [55:0]                 y3_reg;
    logic [49:0]                 nc3_reg, dv3_reg;
    logic [tmd_pkg::NUM_W-1:0]   n4_reg;
    logic [tmd_pkg::MOD_W-1:0]   m4_reg;
    tmd_pkg::iter_t              it5_reg;

    logic [55:0]                 ad_next;
    logic [47:0]                 ff_next, af_next;
    logic                        cruise_next;
    logic [69:0]                 x_next;
    logic [55:0]                 y_next;
    logic [49:0]                 nc_next, dv_next;
    logic [tmd_pkg::NUM_W-1:0]   n_next, lim;
    logic [tmd_pkg::MOD_W-1:0]   m_next;
    logic                        over;
    tmd_pkg::iter_t              it_next;

    always_comb
    begin
        ad_next = 56'(d1_reg) * 56'(a1_reg);
        ff_next = 48'(f1_reg) * 48'(f1_reg);
        af_next = 48'(a1_reg) * 48'(f1_reg);
    end

    always_comb
    begin
        cruise_next = ((64'(ad2_reg) * tmd_pkg::RAMP_K) > 64'({ff2_reg, 2'b00}));
        x_next      = 70'(ad2_reg) * tmd_pkg::CRUISE_AD_K;
        y_next      = 56'(ff2_reg) * tmd_pkg::CRUISE_FF_K;
        nc_next     = 50'(d2_reg) * tmd_pkg::RAMP_D_K;
        dv_next     = 50'(af2_reg) * tmd_pkg::DIV_K;
    end

    always_comb
    begin
        if (cruise3_reg)
        begin
            n_next = (tmd_pkg::NUM_W'(x3_reg) + tmd_pkg::NUM_W'(y3_reg))
                     * tmd_pkg::CRUISE_SCALE_K;
            m_next = tmd_pkg::MOD_W'(dv3_reg);
        end
        else
        begin
            n_next = tmd_pkg::NUM_W'(nc3_reg) * tmd_pkg::RAMP_SCALE_K;
            m_next = tmd_pkg::MOD_W'(a3_reg);
        end
    end

    // quotient or root would need more than 32 bits
    always_comb
    begin
        lim = cruise4_reg ? (tmd_pkg::NUM_W'(m4_reg) << 32) : (tmd_pkg::NUM_W'(m4_reg) << 64);
        over = (n4_reg >= lim);
        it_next.sqrt_mode = !cruise4_reg;
        it_next.done      = dz4_reg || cz4_reg || over;
        it_next.sat       = !dz4_reg && (cz4_reg || over);
        it_next.n         = n4_reg;
        it_next.s         = '0;
        it_next.m         = m4_reg;
        it_next.r_acc     = '0;
        it_next.q         = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg      <= move_distance;
            f1_reg      <= top_feed_rate;
            a1_reg      <= axis_acceleration;
            ad2_reg     <= ad_next;
            ff2_reg     <= ff_next;
            af2_reg     <= af_next;
            d2_reg      <= d1_reg;
            a2_reg      <= a1_reg;
            dz2_reg     <= (d1_reg == '0);
            cz2_reg     <= (f1_reg == '0) || (a1_reg == '0);
            cruise3_reg <= cruise_next;
            x3_reg      <= x_next;
            y3_reg      <= y_next;
            nc3_reg     <= nc_next;
            dv3_reg     <= dv_next;
            a3_reg      <= a2_reg;
            dz3_reg     <= dz2_reg;
            cz3_reg     <= cz2_reg;
            cruise4_reg <= cruise3_reg;
            n4_reg      <= n_next;
            m4_reg      <= m_next;
            dz4_reg     <= dz3_reg;
            cz4_reg     <= cz3_reg;
            it5_reg     <= it_next;
        end
    end

    assign iter_valid = v5_reg;
    assign iter_data  = it5_reg;

endmodule

[rtl/tmd_root_stage.sv]
// one bit of the shared restoring divide / square root recurrence
// depends on tmd_pkg

module tmd_root_stage #(
    parameter int unsigned BIT = 31
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           stage_in_valid,
    input  tmd_pkg::iter_t stage_in,
    output logic           stage_out_valid,
    output tmd_pkg::iter_t stage_out
);

    logic                        valid_reg;
    tmd_pkg::iter_t              data_reg;
    tmd_pkg::iter_t              data_next;
    logic [tmd_pkg::NUM_W-1:0]   m_ext, r_ext, term, trial;
    logic                        take;

    // sqrt: (r + 2^k)^2 * a = s + 2^(k+1) * r * a + 2^(2k) * a
    // divide: (q + 2^k) * m = s + 2^k * m
    always_comb
    begin
        m_ext = tmd_pkg::NUM_W'(stage_in.m);
        r_ext = tmd_pkg::NUM_W'(stage_in.r_acc);
        if (stage_in.sqrt_mode)
            term = (r_ext << (BIT + 1)) + (m_ext << (2 * BIT));
        else
            term = m_ext << BIT;
        trial = stage_in.s + term;
        take  = !stage_in.done && (trial <= stage_in.n);
        data_next = stage_in;
        if (take)
        begin
            data_next.s      = trial;
            data_next.q[BIT] = 1'b1;
            if (stage_in.sqrt_mode)
                data_next.r_acc = stage_in.r_acc + (tmd_pkg::ACC_W'(stage_in.m) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= stage_in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign stage_out_valid = valid_reg;
    assign stage_out       = data_reg;

endmodule

[rtl/trapezoid_move_duration_core.sv]
// top level of the trapezoidal move duration block
// depends on tmd_pkg, tmd_front, tmd_root_stage

// Gives the duration in whole microseconds of a symmetric trapezoidal move for
// each distance beat, one beat per clock unless the pipeline holds. A result
// passes through five front stages (products, constant scaling, mode select,
// range check) and 32 recurrence stages, one quotient or root bit each, every
// recurrence stage a ~90-bit add and compare. When the result beat is not
// taken the whole pipeline holds, so in_ready follows out_ready while a result
// waits. Configuration writes take effect for distances accepted afterwards.

module trapezoid_move_duration_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmd_pkg::DIST_W-1:0]    move_distance,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tmd_pkg::DUR_W-1:0]     duration_us,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmd_pkg::IDX_W-1:0]     cfg_index,
    input  logic [tmd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int unsigned STAGES = tmd_pkg::DUR_W;

    logic [tmd_pkg::CFG_W-1:0] feed_reg, accel_reg;
    logic                      adv, in_fire;
    logic                      chain_valid [0:STAGES];
    tmd_pkg::iter_t            chain_data  [0:STAGES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_reg  <= tmd_pkg::TOP_FEED_RATE_RESET;
            accel_reg <= tmd_pkg::AXIS_ACCELERATION_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tmd_pkg::REG_TOP_FEED_RATE:     feed_reg  <= cfg_data;
                tmd_pkg::REG_AXIS_ACCELERATION: accel_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    assign adv      = !chain_valid[STAGES] || out_ready;
    assign in_ready = adv;
    assign in_fire  = in_valid && in_ready;

    tmd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .in_fire           (in_fire),
        .move_distance     (move_distance),
        .top_feed_rate     (feed_reg),
        .axis_acceleration (accel_reg),
        .iter_valid        (chain_valid[0]),
        .iter_data         (chain_data[0])
    );

    for (genvar g = 0; g < STAGES; g++)
    begin : g_root
        tmd_root_stage #(
            .BIT (STAGES - 1 - g)
        ) u_stage (
            .clk             (clk),
            .rst_n           (rst_n),
            .adv             (adv),
            .stage_in_valid  (chain_valid[g]),
            .stage_in        (chain_data[g]),
            .stage_out_valid (chain_valid[g + 1]),
            .stage_out       (chain_data[g + 1])
        );
    end

    assign out_valid   = chain_valid[STAGES];
    assign saturated   = chain_data[STAGES].sat;
    assign duration_us = chain_data[STAGES].sat ? '1 : chain_data[STAGES].q;

`ifndef ASSERT_OFF
    a_sat_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |-> (!chain_data[0].sat || chain_data[0].done))
        else $error("saturated item not marked done");

    a_done_keeps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chain_data[STAGES].done |-> chain_data[STAGES].q == '0)
        else $error("finished item gained quotient bits");

    a_feed_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == tmd_pkg::REG_TOP_FEED_RATE |=> feed_reg == $past(cfg_data))
        else $error("feed rate write lost");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] && !adv |=> chain_valid[0] && $stable(chain_data[0]))
        else $error("front stage moved during stall");
`endif

endmodule
